[rtl/next_fit_heap_allocator_macros.svh]
// Assertion macros for the heap allocator
`ifndef NEXT_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define NFH_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define NFH_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[rtl/nfh_pkg.sv]
// Shared types and constants of the heap allocator
`default_nettype none
package nfh_pkg;
    localparam int MaxBlocks = 64;
    localparam int HeapBytes = 4096;
    localparam int HdrBytes  = 8;
    localparam int OffW = 13;
    localparam int IdxW = 6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_ROOM = 3'd1;
    localparam logic [2:0] ST_NO_GAP  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_LEN  = 1'b1;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SHIFT, S_OUT} state_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] alloc_size;
        logic [31:0] payload_addr;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_addr;
        logic [12:0] used_bytes;
        logic [6:0]  block_count;
        logic [12:0] free_bytes;
    } rsp_t;

    // chain command, broadcast to all cells
    typedef struct packed {
        logic           ins;      // new entry at sel, cells after take left
        logic           del;      // cells at or after sel take right neighbour
        logic [IdxW-1:0] sel;
        logic [OffW-1:0] new_off;
        logic [OffW-1:0] new_len;
    } cmd_t;
endpackage
`default_nettype wire

[rtl/nfh_cell.sv]
// One table cell: offset and length of one block, shifts with neighbours
`default_nettype none
module nfh_cell (
    input  wire logic            clk,
    input  wire logic [5:0]      pos,
    input  wire nfh_pkg::cmd_t   cmd,
    input  wire logic [12:0]     left_off,
    input  wire logic [12:0]     left_len,
    input  wire logic [12:0]     right_off,
    input  wire logic [12:0]     right_len,
    output logic [12:0]          off,
    output logic [12:0]          len
);
    logic [12:0] off_reg, len_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ins && pos == cmd.sel)
        begin
            off_reg <= cmd.new_off;
            len_reg <= cmd.new_len;
        end
        else if (cmd.ins && pos > cmd.sel)
        begin
            off_reg <= left_off;
            len_reg <= left_len;
        end
        else if (cmd.del && pos >= cmd.sel)
        begin
            off_reg <= right_off;
            len_reg <= right_len;
        end
    end

    assign off = off_reg;
    assign len = len_reg;
endmodule
`default_nettype wire

[rtl/next_fit_heap_allocator.sv]
// Top level: next-fit heap allocator over a shifting chain of block cells
`default_nettype none
`include "next_fit_heap_allocator_macros.svh"
// Each request passes through accept, gap evaluation at every position at
// once, priority pick of the first fitting gap and table shift, and result
// held; one request is handled at a time. The 64-cell chain holds the
// address-ordered block table; an insert or delete shifts every cell past
// the chosen slot at once. A configuration write clears the table. The
// result stays held until taken, and a new request is accepted from the
// cycle after the result leaves.
module next_fit_heap_allocator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire nfh_pkg::req_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output nfh_pkg::rsp_t      out_data
);
    localparam int N = nfh_pkg::MaxBlocks;

    logic [31:0] base_reg;
    logic [12:0] blen_reg;
    logic [6:0]  live_reg, live_next;
    logic [12:0] used_reg, used_next;
    logic [6:0]  start_reg, start_next;
    nfh_pkg::state_t state_reg, state_next;
    nfh_pkg::req_t   req_reg;
    nfh_pkg::rsp_t   rsp_reg, rsp_next;
    nfh_pkg::cmd_t   cmd;
    logic [N-1:0]    hit_reg, fit_reg;
    logic            cfg_hit;

    logic [12:0] off_w [N];
    logic [12:0] len_w [N];

    logic [12:0] eff_len, size13, need;
    logic [16:0] size17;
    logic [12:0] tail;

    always_comb
    begin
        logic [12:0] n;
        n = {blen_reg[12:2], 2'b00};
        if (n > 13'(nfh_pkg::HeapBytes)) n = 13'(nfh_pkg::HeapBytes);
        if (n < 13'd16) n = 13'd16;
        eff_len = n;
    end
    assign tail   = eff_len - 13'd8;
    // rounding may carry past 16 bits
    assign size17 = ({1'b0, req_reg.alloc_size} + 17'd3) & 17'h1FFFC;
    assign size13 = size17[12:0];
    assign need   = size13 + 13'd8;
    assign cfg_hit = cfg_we;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_chain
            logic [12:0] lo, ll, ro, rl;
            if (g == 0)
            begin : g_l0
                assign lo = '0;
                assign ll = '0;
            end
            else
            begin : g_l
                assign lo = off_w[g-1];
                assign ll = len_w[g-1];
            end
            if (g == N-1)
            begin : g_rN
                assign ro = '0;
                assign rl = '0;
            end
            else
            begin : g_r
                assign ro = off_w[g+1];
                assign rl = len_w[g+1];
            end
            nfh_cell u_cell (
                .clk(clk), .pos(6'(g)), .cmd(cmd),
                .left_off(lo), .left_len(ll), .right_off(ro), .right_len(rl),
                .off(off_w[g]), .len(len_w[g])
            );
        end
    endgenerate

    // per-position evaluation: gap before block p (p = 0 head) and free match
    logic [N:0]  fit_c;
    logic [N-1:0] hit_c;
    always_comb
    begin
        logic [12:0] e, nx;
        for (int p = 0; p <= N; p++)
        begin
            e  = (p == 0) ? 13'd8 : off_w[(p == 0) ? 0 : p-1] + len_w[(p == 0) ? 0 : p-1];
            nx = (p >= live_reg) ? tail : off_w[(p >= N) ? N-1 : p];
            fit_c[p] = (7'(p) >= start_reg) && (7'(p) <= live_reg) &&
                       (nx >= e) && ((nx - e) >= need);
        end
        for (int i = 0; i < N; i++)
        begin
            hit_c[i] = (7'(i) < live_reg) &&
                       ({base_reg[31:2], 2'b00} + 32'(off_w[i]) + 32'd8 == req_reg.payload_addr);
        end
    end
    logic fit_last_reg;

    // priority pick of the first fitting gap / matching block
    logic        any_fit, any_hit;
    logic [6:0]  fit_p;
    logic [5:0]  hit_i;
    always_comb
    begin
        any_fit = 1'b0;
        fit_p   = '0;
        for (int p = N; p >= 0; p--)
        begin
            if ((p == N) ? fit_last_reg : fit_reg[(p == N) ? 0 : p])
            begin
                any_fit = 1'b1;
                fit_p   = 7'(p);
            end
        end
        any_hit = 1'b0;
        hit_i   = '0;
        for (int i = N-1; i >= 0; i--)
        begin
            if (hit_reg[i])
            begin
                any_hit = 1'b1;
                hit_i   = 6'(i);
            end
        end
    end

    logic [12:0] sel_end;
    assign sel_end = (fit_p == 7'd0) ? 13'd8 :
                     off_w[6'(fit_p - 7'd1)] + len_w[6'(fit_p - 7'd1)];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfh_pkg::S_IDLE;
            base_reg  <= '0;
            blen_reg  <= 13'd4096;
            live_reg  <= '0;
            used_reg  <= 13'd16;
            start_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_hit)
            begin
                if (cfg_index == nfh_pkg::CFG_BASE) base_reg <= cfg_data;
                else blen_reg <= cfg_data[12:0];
                live_reg  <= '0;
                used_reg  <= 13'd16;
                start_reg <= '0;
            end
            else
            begin
                live_reg  <= live_next;
                used_reg  <= used_next;
                start_reg <= start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) req_reg <= in_data;
        fit_reg      <= fit_c[N-1:0];
        fit_last_reg <= fit_c[N];
        hit_reg      <= hit_c;
        if (state_reg == nfh_pkg::S_SHIFT) rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        live_next  = live_reg;
        used_next  = used_reg;
        start_next = start_reg;
        cmd        = '0;
        rsp_next   = rsp_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            nfh_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) state_next = nfh_pkg::S_EVAL;
            end
            nfh_pkg::S_EVAL: state_next = nfh_pkg::S_SHIFT;
            nfh_pkg::S_SHIFT:
            begin
                state_next = nfh_pkg::S_OUT;
                rsp_next.status      = nfh_pkg::ST_OK;
                rsp_next.result_addr = '0;
                if (req_reg.req_type == nfh_pkg::REQ_ALLOC)
                begin
                    if (size17 > {4'b0000, eff_len - used_reg})
                        rsp_next.status = nfh_pkg::ST_NO_ROOM;
                    else if (live_reg >= 7'(N))
                        rsp_next.status = nfh_pkg::ST_FULL;
                    else if (!any_fit)
                        rsp_next.status = nfh_pkg::ST_NO_GAP;
                    else
                    begin
                        cmd.ins     = 1'b1;
                        cmd.sel     = 6'(fit_p);
                        cmd.new_off = sel_end;
                        cmd.new_len = need;
                        live_next   = live_reg + 7'd1;
                        used_next   = used_reg + need;
                        start_next  = fit_p + 7'd1;
                        rsp_next.result_addr = {base_reg[31:2], 2'b00} +
                                               32'(sel_end) + 32'd8;
                    end
                end
                else if (!any_hit)
                    rsp_next.status = nfh_pkg::ST_UNKNOWN;
                else
                begin
                    cmd.del   = 1'b1;
                    cmd.sel   = hit_i;
                    live_next = live_reg - 7'd1;
                    used_next = used_reg - len_w[hit_i];
                    if (7'(hit_i) + 7'd1 <= start_reg) start_next = 7'(hit_i);
                end
                rsp_next.used_bytes  = used_next;
                rsp_next.block_count = live_next;
                rsp_next.free_bytes  = eff_len - used_next;
            end
            nfh_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready) state_next = nfh_pkg::S_IDLE;
            end
            default: state_next = nfh_pkg::S_IDLE;
        endcase
    end

    assign out_data = rsp_reg;

    `NFH_ASSERT_IMP(a_rdy_idle, clk, rst_n, in_ready, !out_valid, "ready while result held")
    `NFH_ASSERT_IMP(a_live_max, clk, rst_n, 1'b1, live_reg <= 7'(N), "block count overflow")
    `NFH_ASSERT_NEXT(a_acc_eval, clk, rst_n, in_valid && in_ready && !cfg_we,
        state_reg == nfh_pkg::S_EVAL, "accepted item not evaluated")
endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the next-fit heap allocator
`timescale 1ns / 100ps
module testbench;
    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    logic           cfg_index;
    logic [31:0]    cfg_data;
    logic           in_valid;
    logic           in_ready;
    nfh_pkg::req_t  in_data;
    logic           out_valid;
    logic           out_ready;
    nfh_pkg::rsp_t  out_data;

    next_fit_heap_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // heap model state
    logic [31:0] heap_base;
    logic [12:0] heap_reg;
    int          blk_off [nfh_pkg::MaxBlocks];
    int          blk_len [nfh_pkg::MaxBlocks];
    int          n_live;
    int          n_used;
    int          scan_from;

    nfh_pkg::rsp_t pending_rsp[$];
    int            errors;
    bit            calm;          // no idling on either side
    bit            typed_valid;   // expected result of the current item is typed in
    nfh_pkg::rsp_t typed_rsp;

    typedef struct packed {
        nfh_pkg::req_t r;
        bit            has_exp;
        nfh_pkg::rsp_t exp;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int heap_len();
        int n;
        n = heap_reg & 13'h1FFC;
        if (n > nfh_pkg::HeapBytes) n = nfh_pkg::HeapBytes;
        if (n < 2 * nfh_pkg::HdrBytes) n = 2 * nfh_pkg::HdrBytes;
        return n;
    endfunction

    function automatic logic [31:0] base_al();
        return heap_base & 32'hFFFF_FFFC;
    endfunction

    function automatic void clear_heap();
        n_live = 0;
        n_used = 2 * nfh_pkg::HdrBytes;
        scan_from = 0;
    endfunction

    function automatic logic [31:0] payload_of(int i);
        return base_al() + 32'(blk_off[i] + nfh_pkg::HdrBytes);
    endfunction

    // apply one request to the heap model and return the result item
    function automatic nfh_pkg::rsp_t heap_serve(nfh_pkg::req_t r);
        nfh_pkg::rsp_t o;
        int   sz, need, p, e, nx, i;
        bit   done;
        o = '0;
        done = 1'b0;
        if (r.req_type == nfh_pkg::REQ_ALLOC)
        begin
            sz = (int'(r.alloc_size) + 3) & ~3;
            need = sz + nfh_pkg::HdrBytes;
            if (sz > heap_len() - n_used) o.status = nfh_pkg::ST_NO_ROOM;
            else if (n_live >= nfh_pkg::MaxBlocks) o.status = nfh_pkg::ST_FULL;
            else
            begin
                o.status = nfh_pkg::ST_NO_GAP;
                p = (scan_from > n_live) ? n_live : scan_from;
                for (; p <= n_live && !done; p++)
                begin
                    e = (p == 0) ? nfh_pkg::HdrBytes : blk_off[p-1] + blk_len[p-1];
                    nx = (p >= n_live) ? heap_len() - nfh_pkg::HdrBytes : blk_off[p];
                    if (nx >= e && nx - e >= need)
                    begin
                        for (i = n_live; i > p; i--)
                        begin
                            blk_off[i] = blk_off[i-1];
                            blk_len[i] = blk_len[i-1];
                        end
                        blk_off[p] = e;
                        blk_len[p] = need;
                        n_live++;
                        n_used += need;
                        scan_from = p + 1;
                        o.status = nfh_pkg::ST_OK;
                        o.result_addr = base_al() + 32'(e + nfh_pkg::HdrBytes);
                        done = 1'b1;
                    end
                end
            end
        end
        else
        begin
            o.status = nfh_pkg::ST_UNKNOWN;
            for (i = 0; i < n_live && !done; i++)
            begin
                if (payload_of(i) == r.payload_addr)
                begin
                    n_used -= blk_len[i];
                    if (i + 1 <= scan_from) scan_from = i;
                    for (p = i; p + 1 < n_live; p++)
                    begin
                        blk_off[p] = blk_off[p+1];
                        blk_len[p] = blk_len[p+1];
                    end
                    n_live--;
                    o.status = nfh_pkg::ST_OK;
                    done = 1'b1;
                end
            end
        end
        o.used_bytes = 13'(n_used);
        o.block_count = 7'(n_live);
        o.free_bytes = 13'(heap_len() - n_used);
        return o;
    endfunction

    // mostly well-formed traffic: small allocations and frees of live blocks
    function automatic nfh_pkg::req_t pick_item();
        nfh_pkg::req_t r;
        int   k;
        r.req_type = 1'($urandom);
        r.alloc_size = 16'($urandom);
        r.payload_addr = $urandom;
        k = $urandom_range(99);
        if (k < 50)
        begin
            r.req_type = nfh_pkg::REQ_ALLOC;
            r.alloc_size = (k < 5) ? 16'($urandom_range(heap_len()))
                                   : 16'($urandom_range(heap_len() / 8));
        end
        else if (k < 85 && n_live > 0)
        begin
            r.req_type = nfh_pkg::REQ_FREE;
            r.payload_addr = payload_of($urandom_range(n_live - 1));
        end
        else if (k < 92)
        begin
            r.req_type = nfh_pkg::REQ_FREE;
            r.payload_addr = base_al() + 32'($urandom_range(heap_len()));
        end
        return r;
    endfunction

    // item pushed as accepted: model the request, queue its expectation
    always @(posedge clk)
    begin
        nfh_pkg::rsp_t p;
        if (rst_n && in_valid && in_ready)
        begin
            p = heap_serve(in_data);
            pending_rsp.push_back(typed_valid ? typed_rsp : p);
        end
    end

    always @(posedge clk)
    begin
        nfh_pkg::rsp_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result item %p", $time, out_data);
                errors++;
            end
            else
            begin
                w = pending_rsp.pop_front();
                if (out_data.status !== w.status)
                    $display("%0t: status exp %0d got %0d", $time, w.status, out_data.status);
                if (out_data.result_addr !== w.result_addr)
                    $display("%0t: result_addr exp %h got %h", $time, w.result_addr,
                             out_data.result_addr);
                if (out_data.used_bytes !== w.used_bytes)
                    $display("%0t: used_bytes exp %0d got %0d", $time, w.used_bytes,
                             out_data.used_bytes);
                if (out_data.block_count !== w.block_count)
                    $display("%0t: block_count exp %0d got %0d", $time, w.block_count,
                             out_data.block_count);
                if (out_data.free_bytes !== w.free_bytes)
                    $display("%0t: free_bytes exp %0d got %0d", $time, w.free_bytes,
                             out_data.free_bytes);
                if (out_data !== w) errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= calm || ($urandom_range(99) >= 27);
    end

    task automatic send(nfh_pkg::req_t r, bit has_exp, nfh_pkg::rsp_t exp);
        int gap;
        gap = (!calm && $urandom_range(99) < 27) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        typed_valid <= has_exp;
        typed_rsp <= exp;
        do @(posedge clk); while (!in_ready);
    endtask

    // one edge first so the last accepted item is already queued
    task automatic drain();
        in_valid <= 1'b0;
        typed_valid <= 1'b0;
        @(posedge clk);
        wait (pending_rsp.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_heap(logic [31:0] base, logic [31:0] len);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= nfh_pkg::CFG_BASE;
        cfg_data <= base;
        @(posedge clk);
        heap_base = base;
        clear_heap();
        cfg_index <= nfh_pkg::CFG_LEN;
        cfg_data <= len;
        @(posedge clk);
        heap_reg = len[12:0];
        clear_heap();
        cfg_we <= 1'b0;
    endtask

    task automatic random_run(int count);
        repeat (count) send(pick_item(), 1'b0, '0);
    endtask

    row_t plan [16];
    int   idx;

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = nfh_pkg::CFG_BASE;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        typed_valid = 1'b0;
        typed_rsp = '0;
        calm = 1'b0;
        errors = 0;
        heap_base = '0;
        heap_reg = 13'd4096;
        clear_heap();

        // free before any allocation, oversize, zero size, then model-checked rows
        plan[0]  = '{'{nfh_pkg::REQ_FREE, 16'd0, 32'h10}, 1'b1,
                     '{nfh_pkg::ST_UNKNOWN, 32'd0, 13'd16, 7'd0, 13'd4080}};
        plan[1]  = '{'{nfh_pkg::REQ_ALLOC, 16'hFFFF, 32'd0}, 1'b1,
                     '{nfh_pkg::ST_NO_ROOM, 32'd0, 13'd16, 7'd0, 13'd4080}};
        plan[2]  = '{'{nfh_pkg::REQ_ALLOC, 16'd0, 32'hFFFF_FFFF}, 1'b1,
                     '{nfh_pkg::ST_OK, 32'd16, 13'd24, 7'd1, 13'd4072}};
        plan[3]  = '{'{nfh_pkg::REQ_ALLOC, 16'd1, 32'd0}, 1'b0, '0};
        plan[4]  = '{'{nfh_pkg::REQ_ALLOC, 16'd6, 32'd0}, 1'b0, '0};
        plan[5]  = '{'{nfh_pkg::REQ_FREE, 16'd0, 32'd16}, 1'b0, '0};
        plan[6]  = '{'{nfh_pkg::REQ_FREE, 16'hFFFF, 32'd16}, 1'b0, '0};
        plan[7]  = '{'{nfh_pkg::REQ_FREE, 16'd0, 32'd8}, 1'b0, '0};
        plan[8]  = '{'{nfh_pkg::REQ_FREE, 16'd0, 32'hFFFF_FFFF}, 1'b0, '0};
        plan[9]  = '{'{nfh_pkg::REQ_ALLOC, 16'd4, 32'd0}, 1'b0, '0};
        plan[10] = '{'{nfh_pkg::REQ_ALLOC, 16'd4000, 32'd0}, 1'b0, '0};
        plan[11] = '{'{nfh_pkg::REQ_ALLOC, 16'd40, 32'd0}, 1'b0, '0};
        plan[12] = '{'{nfh_pkg::REQ_FREE, 16'd0, 32'd24}, 1'b0, '0};
        plan[13] = '{'{nfh_pkg::REQ_ALLOC, 16'd0, 32'd0}, 1'b0, '0};
        plan[14] = '{'{nfh_pkg::REQ_ALLOC, 16'd3, 32'd0}, 1'b0, '0};
        plan[15] = '{'{nfh_pkg::REQ_ALLOC, 16'd4, 32'd0}, 1'b0, '0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < 16; idx++) send(plan[idx].r, plan[idx].has_exp, plan[idx].exp);
        random_run(60);
        drain();                        // sender waits for every result
        random_run(40);

        // table full: 64 small blocks, then more
        set_heap(32'h1000_0003, 32'h0000_1FFF);
        repeat (70) send('{nfh_pkg::REQ_ALLOC, 16'($urandom_range(3)), 32'd0}, 1'b0, '0);
        random_run(60);

        // smallest heap: nothing fits
        set_heap(32'hFFFF_FFFF, 32'd16);
        send('{nfh_pkg::REQ_ALLOC, 16'd0, 32'd0}, 1'b0, '0);
        random_run(15);

        set_heap(32'hFFFF_FFFC, 32'd100);
        calm = 1'b1;
        random_run(120);
        calm = 1'b0;

        set_heap(32'h8000_0000, 32'd3);
        random_run(15);

        set_heap(32'h1234_5678, 32'd256);
        random_run(120);

        set_heap($urandom, $urandom_range(16, 600));
        random_run(120);

        set_heap(32'd0, 32'd4096);
        random_run(100);

        drain();
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("testbench failed");
        $finish;
    end
endmodule
